@@ src/fractional_delay_lagrange_core_defines.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef FRACTIONAL_DELAY_LAGRANGE_CORE_DEFINES_SVH
`define FRACTIONAL_DELAY_LAGRANGE_CORE_DEFINES_SVH

// prop must hold at every edge
`define FDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// cons must hold in the same cycle as ante
`define FDL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define FDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fdl_pkg.sv @@
package fdl_pkg;

  localparam int DEPTH_LOG2 = 12;
  localparam int DEPTH      = 1 << DEPTH_LOG2;
  localparam int FRAC_W     = 16;
  localparam int DW         = DEPTH_LOG2 + FRAC_W;   // clamped delay / read point
  localparam int CFG_W      = 28;
  localparam int CW         = (DW > CFG_W) ? DW : CFG_W;
  localparam int SAMPLE_W   = 24;
  localparam int HW         = 32;                    // Horner accumulator
  localparam int BW         = 29;                    // second multiplier operand
  localparam int PW         = HW + BW;               // product
  localparam int DIV_SHIFT  = 30;

  localparam logic [CW-1:0] DLY_LO    = CW'(1) << FRAC_W;
  localparam logic [CW-1:0] DLY_HI    = CW'(DEPTH - 4) << FRAC_W;
  localparam logic [DW-1:0] DLY_RESET = DW'(1) << FRAC_W;

  // ceil(2^30 / 6): exact floor division by six for operands below 2^27
  localparam logic signed [BW-1:0] DIV_MUL = BW'((2**DIV_SHIFT + 5) / 6);
  // six times the full-scale magnitude; beyond it the output saturates anyway
  localparam logic signed [HW-1:0] SAT_T   = HW'(6 * 2**(SAMPLE_W-1));

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } fdl_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_COEF,
    ST_MUL,
    ST_ACC,
    ST_PREP,
    ST_DIVM,
    ST_DIVA
  } fdl_state_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic rd_en;
  } fdl_store_cmd_t;

  typedef struct packed {
    logic en;
    logic recip;   // multiply by DIV_MUL instead of the fraction
  } fdl_mul_cmd_t;

endpackage

@@ src/fdl_store.sv @@
`include "fractional_delay_lagrange_core_defines.svh"

module fdl_store (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  fdl_pkg::fdl_store_cmd_t                  cmd_i,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0]      wdata_i,
  input  logic        [fdl_pkg::DEPTH_LOG2-1:0]    raddr_i,
  output logic        [fdl_pkg::DEPTH_LOG2-1:0]    wr_idx_o,
  output logic signed [fdl_pkg::SAMPLE_W-1:0]      rdata_o,
  output logic                                     rvalid_o
);

  localparam logic [fdl_pkg::DEPTH_LOG2-1:0] IDX_MAX = '1;

  logic signed [fdl_pkg::SAMPLE_W-1:0] mem [fdl_pkg::DEPTH];
  logic signed [fdl_pkg::SAMPLE_W-1:0] rdata_q;
  logic [fdl_pkg::DEPTH_LOG2-1:0]      wr_idx_q, wr_idx_d;
  logic                                full_q, full_d;
  logic                                rvalid_q;
  logic                                rd_ok_q;
  logic                                rd_ok;

  // Writes since a clear run upwards from entry 0, so an entry below the
  // write index, or any entry once the index has wrapped, holds real data.
  assign rd_ok = full_q | (raddr_i < wr_idx_q);

  always_comb begin
    wr_idx_d = wr_idx_q;
    full_d   = full_q;
    if (cmd_i.clear) begin
      wr_idx_d = '0;
      full_d   = 1'b0;
    end else if (cmd_i.push) begin
      wr_idx_d = wr_idx_q + fdl_pkg::DEPTH_LOG2'(1);
      full_d   = full_q | (wr_idx_q == IDX_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      full_q   <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      full_q   <= full_d;
      rvalid_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_idx_q] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_i];
      rd_ok_q <= rd_ok;
    end
  end

  assign wr_idx_o = wr_idx_q;
  assign rdata_o  = rd_ok_q ? rdata_q : '0;
  assign rvalid_o = rvalid_q;

  `FDL_ASSERT_NEXT(clear_resets_a, cmd_i.clear, (wr_idx_q == '0) && !full_q, "clear left state")
  `FDL_ASSERT_IMPLIES(full_wrap_a, $rose(full_q), $past(wr_idx_q) == IDX_MAX, "full without wrap")
  `FDL_ASSERT_IMPLIES(rvalid_src_a, rvalid_q, $past(cmd_i.rd_en), "read data without request")

endmodule

@@ src/fdl_mul.sv @@
module fdl_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdl_pkg::fdl_mul_cmd_t               cmd_i,
  input  logic signed [fdl_pkg::HW-1:0]       a_i,
  input  logic        [fdl_pkg::FRAC_W-1:0]   frac_i,
  output logic signed [fdl_pkg::PW-1:0]       prod_o
);

  logic signed [fdl_pkg::BW-1:0] b;
  logic signed [fdl_pkg::PW-1:0] prod_q;

  always_comb begin
    if (cmd_i.recip) begin
      b = fdl_pkg::DIV_MUL;
    end else begin
      b = signed'(fdl_pkg::BW'(frac_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (cmd_i.en) begin
      prod_q <= a_i * b;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ src/fractional_delay_lagrange_core.sv @@
// Fractional delay line with cubic Lagrange read-out. Push and clear take one
// beat each and the core is ready again the next cycle; clear is instant (no
// sweep of the store). A pop keeps the input side busy until its result is
// loaded into the output register: four taps are read one per cycle from
// the sample store, then one shared multiplier does the three Horner steps
// and the final divide-by-six, each as a multiply step and an accumulate step.
// The result goes to an output register, so the next item is taken while a
// result waits. The delay register is clamped to 1.0..DEPTH-4 when written.
`include "fractional_delay_lagrange_core_defines.svh"

module fractional_delay_lagrange_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [fdl_pkg::CFG_W-1:0]      cfg_delay_amount_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [1:0]                     opcode_i,
  input  logic signed [fdl_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fdl_pkg::SAMPLE_W-1:0]   sample_out_o
);

  localparam int DL = fdl_pkg::DEPTH_LOG2;
  localparam int HW = fdl_pkg::HW;
  localparam int SW = fdl_pkg::SAMPLE_W;
  localparam logic signed [HW-1:0] U_MAX = fdl_pkg::SAT_T <<< 1;

  fdl_pkg::fdl_state_e state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;

  logic [fdl_pkg::DW-1:0]     delay_q;
  logic [fdl_pkg::CW-1:0]     cfg_ext, cfg_clamped;
  logic [DL-1:0]              base_q;
  logic [fdl_pkg::FRAC_W-1:0] frac_q;
  logic [fdl_pkg::DW-1:0]     rd_pt;
  logic signed [SW-1:0]       tap_q [4];
  logic signed [HW-1:0]       c1_q, c2_q, h_q;
  logic signed [SW-1:0]       out_q;
  logic                       out_valid_q;

  logic accept, out_free, pop_accept;
  logic ld_coef, ld_acc, ld_prep, ld_out;

  fdl_pkg::fdl_store_cmd_t st_cmd;
  fdl_pkg::fdl_mul_cmd_t   mul_cmd;
  logic [DL-1:0]           raddr, wr_idx;
  logic signed [SW-1:0]    rdata;
  logic                    rvalid;
  logic signed [fdl_pkg::PW-1:0] prod;

  // datapath values
  logic signed [HW-1:0] e0, e1, e2, e3, s2, c1, c2, c3, six_y1;
  logic signed [fdl_pkg::PW-1:0] psum, pshift;
  logic signed [HW-1:0] csel, acc_sum, t, tc, u;
  logic [SW:0]          q;
  logic signed [SW-1:0] sat;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_ext = fdl_pkg::CW'(cfg_delay_amount_i);
    if (cfg_ext < fdl_pkg::DLY_LO) begin
      cfg_clamped = fdl_pkg::DLY_LO;
    end else if (cfg_ext > fdl_pkg::DLY_HI) begin
      cfg_clamped = fdl_pkg::DLY_HI;
    end else begin
      cfg_clamped = cfg_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= fdl_pkg::DLY_RESET;
    end else if (cfg_we_i) begin
      delay_q <= cfg_clamped[fdl_pkg::DW-1:0];
    end
  end

  // read point, modulo the store size, with 16 fraction bits
  assign rd_pt = {wr_idx, {fdl_pkg::FRAC_W{1'b0}}} - delay_q;

  // ---------------- sequencer ----------------
  assign accept     = in_valid_i & in_ready_o;
  assign pop_accept = accept && (opcode_i == fdl_pkg::OP_POP);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      fdl_pkg::ST_IDLE: begin
        if (pop_accept) begin
          state_d = fdl_pkg::ST_READ;
          cnt_d   = 2'd0;
        end
      end
      fdl_pkg::ST_READ: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = fdl_pkg::ST_WAIT;
        end
      end
      fdl_pkg::ST_WAIT: begin
        state_d = fdl_pkg::ST_COEF;
      end
      fdl_pkg::ST_COEF: begin
        state_d = fdl_pkg::ST_MUL;
        cnt_d   = 2'd0;
      end
      fdl_pkg::ST_MUL: begin
        state_d = fdl_pkg::ST_ACC;
      end
      fdl_pkg::ST_ACC: begin
        if (cnt_q == 2'd2) begin
          state_d = fdl_pkg::ST_PREP;
          cnt_d   = 2'd0;
        end else begin
          state_d = fdl_pkg::ST_MUL;
          cnt_d   = cnt_q + 2'd1;
        end
      end
      fdl_pkg::ST_PREP: begin
        state_d = fdl_pkg::ST_DIVM;
      end
      fdl_pkg::ST_DIVM: begin
        state_d = fdl_pkg::ST_DIVA;
      end
      fdl_pkg::ST_DIVA: begin
        if (out_free) begin
          state_d = fdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdl_pkg::ST_IDLE;
        cnt_d   = 2'd0;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    st_cmd        = '0;
    mul_cmd       = '0;
    ld_coef       = 1'b0;
    ld_acc        = 1'b0;
    ld_prep       = 1'b0;
    ld_out        = 1'b0;
    case (state_q)
      fdl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          case (opcode_i)
            fdl_pkg::OP_PUSH:  st_cmd.push  = 1'b1;
            fdl_pkg::OP_CLEAR: st_cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      fdl_pkg::ST_READ: st_cmd.rd_en = 1'b1;
      fdl_pkg::ST_COEF: ld_coef = 1'b1;
      fdl_pkg::ST_MUL:  mul_cmd.en = 1'b1;
      fdl_pkg::ST_ACC:  ld_acc = 1'b1;
      fdl_pkg::ST_PREP: ld_prep = 1'b1;
      fdl_pkg::ST_DIVM: begin
        mul_cmd.en    = 1'b1;
        mul_cmd.recip = 1'b1;
      end
      fdl_pkg::ST_DIVA: ld_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdl_pkg::ST_IDLE;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  assign raddr = base_q + DL'(cnt_q);

  assign e0 = HW'(tap_q[0]);
  assign e1 = HW'(tap_q[1]);
  assign e2 = HW'(tap_q[2]);
  assign e3 = HW'(tap_q[3]);

  // coefficients scaled by six
  assign six_y1 = (e1 <<< 2) + (e1 <<< 1);
  assign c1 = (e2 <<< 2) + (e2 <<< 1) - (e0 <<< 1) - (e1 <<< 1) - e1 - e3;
  assign s2 = e0 - (e1 <<< 1) + e2;
  assign c2 = (s2 <<< 1) + s2;
  assign c3 = e3 - (e2 <<< 1) - e2 + (e1 <<< 1) + e1 - e0;

  // round half up on the product, then add the next coefficient
  assign psum   = prod + (fdl_pkg::PW'(1) <<< (fdl_pkg::FRAC_W - 1));
  assign pshift = psum >>> fdl_pkg::FRAC_W;

  always_comb begin
    case (cnt_q)
      2'd0:    csel = c2_q;
      2'd1:    csel = c1_q;
      default: csel = six_y1;
    endcase
  end

  assign acc_sum = csel + signed'(pshift[HW-1:0]);

  // floor((h+3)/6): clip to the saturating range, offset to non-negative,
  // then multiply by the reciprocal
  always_comb begin
    t = h_q + HW'(3);
    if (t > fdl_pkg::SAT_T) begin
      tc = fdl_pkg::SAT_T;
    end else if (t < -fdl_pkg::SAT_T) begin
      tc = -fdl_pkg::SAT_T;
    end else begin
      tc = t;
    end
    u = tc + fdl_pkg::SAT_T;
  end

  assign q   = prod[fdl_pkg::DIV_SHIFT +: SW+1];
  assign sat = q[SW] ? fdl_pkg::SAMPLE_MAX : signed'({~q[SW-1], q[SW-2:0]});

  always_ff @(posedge clk_i) begin
    if (pop_accept) begin
      base_q <= rd_pt[fdl_pkg::DW-1:fdl_pkg::FRAC_W] - DL'(1);
      frac_q <= rd_pt[fdl_pkg::FRAC_W-1:0];
    end
    if (rvalid) begin
      tap_q[0] <= tap_q[1];
      tap_q[1] <= tap_q[2];
      tap_q[2] <= tap_q[3];
      tap_q[3] <= rdata;
    end
    if (ld_coef) begin
      c1_q <= c1;
      c2_q <= c2;
      h_q  <= c3;
    end else if (ld_acc) begin
      h_q <= acc_sum;
    end else if (ld_prep) begin
      h_q <= u;
    end
    if (ld_out) begin
      out_q <= sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  fdl_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (st_cmd),
    .wdata_i  (sample_in_i),
    .raddr_i  (raddr),
    .wr_idx_o (wr_idx),
    .rdata_o  (rdata),
    .rvalid_o (rvalid)
  );

  fdl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (h_q),
    .frac_i (frac_q),
    .prod_o (prod)
  );

  `FDL_ASSERT_NEXT(pop_start_a, pop_accept, state_q == fdl_pkg::ST_READ, "pop not started")
  `FDL_ASSERT_IMPLIES(coef_seq_a, ld_coef, $past(state_q) == fdl_pkg::ST_WAIT, "taps not ready")
  `FDL_ASSERT_IMPLIES(div_arg_a, mul_cmd.recip, (h_q >= 0) && (h_q <= U_MAX), "bad divide operand")
  `FDL_ASSERT_IMPLIES(out_load_a, ld_out, out_free, "result overwrites waiting beat")

endmodule

@@ tb/sv/fractional_delay_lagrange_checker.sv @@
`timescale 1ns / 100ps

module fractional_delay_lagrange_checker
  import fdl_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic        [CFG_W-1:0]    cfg_delay_amount_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_o,
  input  logic        [1:0]          opcode_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_out_o,
  output int                         mismatch_count,
  output int                         results_pending
);

  localparam longint IDX_MASK  = DEPTH - 1;
  localparam longint DELAY_MIN = longint'(1) << FRAC_W;
  localparam longint DELAY_MAX = longint'(DEPTH - 4) << FRAC_W;
  localparam longint OUT_MAX   = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN   = -(longint'(1) << (SAMPLE_W - 1));

  logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
  logic        [DEPTH_LOG2-1:0] wr_idx;
  logic        [CFG_W-1:0]    delay_reg;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want;

  task automatic wipe_store();
    for (int k = 0; k < DEPTH; k++) sample_mem[k] = '0;
    wr_idx = '0;
  endtask

  // floor((v + 2^15) / 2^16)
  function automatic longint round16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] interp_delayed();
    longint d, p, base, frac;
    longint y0, y1, y2, y3, c1, c2, c3, h, t, q;
    d = longint'(delay_reg);
    if (d < DELAY_MIN) d = DELAY_MIN;
    if (d > DELAY_MAX) d = DELAY_MAX;
    p    = ((longint'(wr_idx) + DEPTH) << FRAC_W) - d;
    base = p >>> FRAC_W;
    frac = p & 64'hFFFF;
    y0 = sample_mem[(base - 1) & IDX_MASK];
    y1 = sample_mem[base & IDX_MASK];
    y2 = sample_mem[(base + 1) & IDX_MASK];
    y3 = sample_mem[(base + 2) & IDX_MASK];
    c1 = 6 * y2 - 2 * y0 - 3 * y1 - y3;
    c2 = 3 * (y0 - 2 * y1 + y2);
    c3 = y3 - 3 * y2 + 3 * y1 - y0;
    h = c3;
    h = c2 + round16(h * frac);
    h = c1 + round16(h * frac);
    h = 6 * y1 + round16(h * frac);
    // divide by six rounding half up, floor on negatives
    t = h + 3;
    q = t / 6;
    if ((t % 6) != 0 && t < 0) q = q - 1;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    return SAMPLE_W'(q);
  endfunction

  task automatic note_mismatch(input string what, input logic signed [SAMPLE_W-1:0] exp_v,
                               input logic signed [SAMPLE_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_store();
      delay_reg = DLY_RESET;
      expected_samples.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          note_mismatch("sample_out beat with no pop waiting", '0, sample_out_o);
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_o !== want) note_mismatch("sample_out mismatch", want, sample_out_o);
        end
      end
      if (cfg_we_i) delay_reg = cfg_delay_amount_i;
      if (in_valid_i && in_ready_o) begin
        case (opcode_i)
          OP_PUSH: begin
            sample_mem[wr_idx] = sample_in_i;
            wr_idx = wr_idx + DEPTH_LOG2'(1);
          end
          OP_POP:   expected_samples.push_back(interp_delayed());
          OP_CLEAR: wipe_store();
          default:  ;
        endcase
      end
    end
    results_pending = expected_samples.size();
  end

endmodule

@@ tb/sv/fractional_delay_lagrange_core_test.sv @@
`timescale 1ns / 100ps

module fractional_delay_lagrange_core_test;
  import fdl_pkg::*;

  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam int         NUM_PHASES   = 8;
  localparam int         PHASE_ITEMS  = 180;
  localparam int         DRAIN_CYCLES = 32;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         IDLE_LIMIT   = 5000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = SAMPLE_MAX;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] DELAY_CEIL = CFG_W'(DEPTH - 4) << FRAC_W;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE_STALL,
    RX_TRICKLE
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_delay_amount_i = '0;
  logic in_valid_i = 1'b0;
  logic [1:0] opcode_i = OP_PUSH;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [SAMPLE_W-1:0] sample_out_o;

  logic hold_req = 1'b0;
  int   mismatch_count;
  int   results_pending;
  int   burst_left = 0;

  always #2 clk_i = ~clk_i;

  fractional_delay_lagrange_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_delay_amount_i (cfg_delay_amount_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .sample_in_i        (sample_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sample_out_o       (sample_out_o)
  );

  fractional_delay_lagrange_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_delay_amount_i (cfg_delay_amount_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .sample_in_i        (sample_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sample_out_o       (sample_out_o),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // receiver: changing stall pattern, plus one long hold-off on request
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       hold_cnt = 0;
  logic     hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_cnt  = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 400);
      end else begin
        rx_left = rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:         out_ready_i <= 1'b1;
        RX_COIN:         out_ready_i <= $urandom_range(0, 1);
        RX_SPARSE_STALL: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:         out_ready_i <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // bursts of back-to-back beats separated by random gaps
  task automatic send_item(input logic [1:0] op, input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 16);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_delay(input logic [CFG_W-1:0] value);
    settle();
    cfg_we_i           <= 1'b1;
    cfg_delay_amount_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SAMPLE_W'($urandom_range(0, 255)) - SAMPLE_W'(128);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_delay(input int phase);
    case (phase)
      0:       return '0;
      1:       return {CFG_W{1'b1}};
      2:       return DELAY_CEIL;
      7:       return CFG_W'($urandom());
      default: return (CFG_W'($urandom_range(0, 12)) << FRAC_W) |
                      CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58)      send_item(OP_PUSH, pick_sample());
    else if (r < 95) send_item(OP_POP, SAMPLE_W'($urandom()));
    else if (r < 97) send_item(OP_CLEAR, SAMPLE_W'($urandom()));
    else             send_item(OP_RESERVED, SAMPLE_W'($urandom()));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset delay of one sample: empty store, extremes, reserved opcode, clear
    send_item(OP_POP, S_MAX);
    send_item(OP_PUSH, S_MAX);
    send_item(OP_PUSH, S_MIN);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, -1);
    send_item(OP_POP, '0);
    send_item(OP_RESERVED, SAMPLE_W'($urandom()));
    send_item(OP_POP, S_MIN);
    send_item(OP_CLEAR, S_MAX);
    send_item(OP_POP, '0);

    // delay below one sample is raised to one
    set_delay('0);
    send_item(OP_PUSH, 24'sh123456);
    send_item(OP_POP, '0);

    // delay above the ceiling is lowered to it
    set_delay({CFG_W{1'b1}});
    send_item(OP_POP, '0);

    // half-sample point between two full-scale peaks overshoots: saturation
    set_delay(CFG_W'(32'h0002_8000));
    send_item(OP_PUSH, S_MIN);
    send_item(OP_PUSH, S_MAX);
    send_item(OP_PUSH, S_MAX);
    send_item(OP_PUSH, S_MIN);
    send_item(OP_POP, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_delay(pick_delay(ph));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          // long receiver hold-off while pops keep coming
          hold_req   <= 1'b1;
          burst_left = 40;
          for (int m = 0; m < 16; m++) send_item(OP_POP, SAMPLE_W'($urandom()));
        end
        random_item();
      end
    end

    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
